// ===== design/f2f8_pkg.sv =====
// Shared types and constants for the float to FP8 quantizer.
`default_nettype none
package f2f8_pkg;

  // Configuration register indexes
  localparam logic CFG_SOURCE_FORMAT = 1'b0;
  localparam logic CFG_TARGET_FORMAT = 1'b1;

  // Format codes
  localparam logic SRC_FP16 = 1'b0;
  localparam logic SRC_FP32 = 1'b1;
  localparam logic TGT_E4M3 = 1'b0;
  localparam logic TGT_E5M2 = 1'b1;

  // Source bias minus target bias
  localparam logic [9:0] BIAS_FP32_E4M3 = 10'd120;
  localparam logic [9:0] BIAS_FP32_E5M2 = 10'd112;
  localparam logic [9:0] BIAS_FP16_E4M3 = 10'd8;
  localparam logic [9:0] BIAS_FP16_E5M2 = 10'd0;

  // Saturation / special codes (without sign)
  localparam logic [6:0] E4M3_SAT = 7'h7E;
  localparam logic [6:0] E5M2_INF = 7'h7C;
  localparam logic [6:0] E5M2_NAN = 7'h7F;

  // Decoded source word, mantissa left-aligned to 23 bits
  typedef struct packed {
    logic        sign;
    logic        e5m2;
    logic        special;  // all-ones exponent
    logic        nan;
    logic        zero;
    logic        keep_sub; // FP16 subnormal kept as E5M2 with exponent 0
    logic [9:0]  te;       // unbiased-to-target exponent, two's complement
    logic [22:0] man;
  } unpacked_t;

endpackage
`default_nettype wire

// ===== design/f2f8_unpack.sv =====
// Stage 1: field extraction and exponent rebias of the source word.
`default_nettype none
module f2f8_unpack (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                in_valid,
  input  wire logic [31:0]         source_bits,
  input  wire logic                source_format,
  input  wire logic                target_format,
  output logic                     out_valid,
  output f2f8_pkg::unpacked_t      out_item
);

  logic [7:0]          ef;
  logic [22:0]         mf;
  logic [9:0]          bias_diff;
  f2f8_pkg::unpacked_t item_next;

  always_comb begin
    if (source_format == f2f8_pkg::SRC_FP32) begin
      ef = source_bits[30:23];
      mf = source_bits[22:0];
      bias_diff = (target_format == f2f8_pkg::TGT_E5M2) ? f2f8_pkg::BIAS_FP32_E5M2
                                                         : f2f8_pkg::BIAS_FP32_E4M3;
      item_next.sign    = source_bits[31];
      item_next.special = (ef == 8'hFF);
    end else begin
      ef = {3'b000, source_bits[14:10]};
      mf = {source_bits[9:0], 13'd0};
      bias_diff = (target_format == f2f8_pkg::TGT_E5M2) ? f2f8_pkg::BIAS_FP16_E5M2
                                                         : f2f8_pkg::BIAS_FP16_E4M3;
      item_next.sign    = source_bits[15];
      item_next.special = (ef[4:0] == 5'h1F);
    end
    item_next.e5m2     = (target_format == f2f8_pkg::TGT_E5M2);
    item_next.nan      = (mf != 23'd0);
    item_next.zero     = (ef == 8'd0) && (mf == 23'd0);
    item_next.keep_sub = (ef == 8'd0) && (source_format == f2f8_pkg::SRC_FP16) &&
                         (target_format == f2f8_pkg::TGT_E5M2);
    item_next.te       = {2'b00, ef} - bias_diff;
    item_next.man      = mf;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else begin
      out_valid <= in_valid;
    end
    out_item <= item_next;
  end

endmodule
`default_nettype wire

// ===== design/float_to_fp8_quantizer.sv =====
// Top level: FP16/FP32 to FP8 E4M3/E5M2 quantizer, three-stage pipeline.
//
//  channel   signals                          direction  notes
//  input     start, busy, source_bits         in/out     accepted on start && !busy
//  result    done, fp8_code                   out        valid one cycle, no backpressure
//  config    cfg_write, cfg_index, cfg_data   in         write on cfg_write
//
// One item per cycle, with no stall.
// Each result passes through three register stages: unpack, classify/round, pack.
// busy is tied low: the pipeline never stalls since results cannot be held off.
// Synchronous reset clears the valid bits and sets both formats to 0 (FP16, E4M3).
`default_nettype none
module float_to_fp8_quantizer (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        start,
  output logic             busy,
  input  wire logic [31:0] source_bits,
  output logic             done,
  output logic [7:0]       fp8_code,
  input  wire logic        cfg_write,
  input  wire logic        cfg_index,
  input  wire logic        cfg_data
);

  logic source_format;
  logic target_format;

  always_ff @(posedge clk) begin
    if (rst) begin
      source_format <= f2f8_pkg::SRC_FP16;
      target_format <= f2f8_pkg::TGT_E4M3;
    end else if (cfg_write) begin
      unique case (cfg_index)
        f2f8_pkg::CFG_SOURCE_FORMAT: source_format <= cfg_data;
        f2f8_pkg::CFG_TARGET_FORMAT: target_format <= cfg_data;
        default: ;
      endcase
    end
  end

  assign busy = 1'b0;

  // Stage 1
  logic                v1;
  f2f8_pkg::unpacked_t s1;

  f2f8_unpack u_unpack (
    .clk           (clk),
    .rst           (rst),
    .in_valid      (start && !busy),
    .source_bits   (source_bits),
    .source_format (source_format),
    .target_format (target_format),
    .out_valid     (v1),
    .out_item      (s1)
  );

  // Stage 2: specials, range checks, subnormal truncation, mantissa rounding
  logic signed [9:0] te_s;
  logic [2:0]        shamt;
  logic [3:0]        sub_top;
  logic [3:0]        sub_val;
  logic              fixed_next;
  logic [6:0]        code_next;
  logic [4:0]        te_next;
  logic [3:0]        tm_next;

  logic              v2;
  logic              sign2;
  logic              e5m2_2;
  logic              fixed2;
  logic [6:0]        code2;
  logic [4:0]        te2;
  logic [3:0]        tm2;

  always_comb begin
    te_s    = $signed(s1.te);
    shamt   = 3'd1 - s1.te[2:0];
    sub_top = s1.e5m2 ? {2'b01, s1.man[22:21]} : {1'b1, s1.man[22:20]};
    sub_val = sub_top >> shamt;
    fixed_next = 1'b1;
    code_next  = 7'd0;
    te_next    = s1.keep_sub ? 5'd0 : s1.te[4:0];
    tm_next    = s1.e5m2 ? ({2'b00, s1.man[22:21]} + {3'b000, s1.man[20]})
                         : ({1'b0, s1.man[22:20]} + {3'b000, s1.man[19]});
    priority if (s1.special) begin
      code_next = !s1.e5m2 ? f2f8_pkg::E4M3_SAT
                           : (s1.nan ? f2f8_pkg::E5M2_NAN : f2f8_pkg::E5M2_INF);
    end else if (s1.zero) begin
      code_next = 7'd0;
    end else if (!s1.e5m2 && te_s > 10'sd15) begin
      code_next = f2f8_pkg::E4M3_SAT;
    end else if (s1.e5m2 && te_s >= 10'sd31) begin
      code_next = f2f8_pkg::E5M2_INF;
    end else if (s1.keep_sub) begin
      fixed_next = 1'b0;
    end else if (te_s <= 10'sd0) begin
      // subnormal result: truncate, or flush below the smallest step
      if (te_s < (s1.e5m2 ? -10'sd2 : -10'sd3)) begin
        code_next = 7'd0;
      end else begin
        code_next = {4'd0, sub_val[2:0] & (s1.e5m2 ? 3'b011 : 3'b111)};
      end
    end else begin
      fixed_next = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v2 <= 1'b0;
    end else begin
      v2 <= v1;
    end
    sign2  <= s1.sign;
    e5m2_2 <= s1.e5m2;
    fixed2 <= fixed_next;
    code2  <= code_next;
    te2    <= te_next;
    tm2    <= tm_next;
  end

  // Stage 3: mantissa carry, final saturation and packing
  logic       carry;
  logic [4:0] te_fin;
  logic [2:0] tm_fin;
  logic [6:0] mag;
  logic       e5m2_3;

  always_comb begin
    carry  = e5m2_2 ? tm2[2] : tm2[3];
    te_fin = te2 + {4'd0, carry};
    tm_fin = carry ? 3'd0 : tm2[2:0];
    if (fixed2) begin
      mag = code2;
    end else if (!e5m2_2) begin
      if (te_fin > 5'd15 || (te_fin == 5'd15 && tm_fin > 3'd6)) begin
        mag = f2f8_pkg::E4M3_SAT;
      end else begin
        mag = {te_fin[3:0], tm_fin};
      end
    end else begin
      if (te_fin == 5'd31) begin
        mag = f2f8_pkg::E5M2_INF;
      end else begin
        mag = {te_fin, tm_fin[1:0]};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= v2;
    end
    fp8_code <= {sign2, mag};
    e5m2_3   <= e5m2_2;
  end

`ifndef SYNTH
  // every accepted transaction yields a matching result on done
  a_latency: assert property (@(posedge clk) disable iff (rst)
    start && !busy |-> ##3 done)
    else $error("result missing three cycles after start");

  a_no_orphan: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(start && !busy, 3))
    else $error("result without a matching start");

  // E4M3 never produces the NaN encoding
  a_e4m3_no_nan: assert property (@(posedge clk) disable iff (rst)
    done && !e5m2_3 |-> fp8_code[6:0] != 7'h7F)
    else $error("E4M3 NaN code emitted");
`endif

endmodule
`default_nettype wire

// ===== tb/sv/tb_top.sv =====
// Self-checking testbench for the float to FP8 quantizer.
`timescale 1ns / 1ps
module tb_top;

  localparam int WATCHDOG_LIMIT = 2000;
  localparam int PIPE_LATENCY = 3;

  logic        clk;
  logic        rst;
  logic        start;
  logic        busy;
  logic [31:0] source_bits;
  logic        done;
  logic [7:0]  fp8_code;
  logic        cfg_write;
  logic        cfg_index;
  logic        cfg_data;

  typedef struct {
    logic [31:0] src;
    logic        src_fmt;
    logic        tgt_fmt;
    logic [7:0]  code;
  } fp8_expect_t;

  fp8_expect_t expected_codes[$];
  logic        cur_src_fmt;
  logic        cur_tgt_fmt;
  int          mismatch_count;
  int          idle_cycles;

  float_to_fp8_quantizer DUT (
    .clk(clk),
    .rst(rst),
    .start(start),
    .busy(busy),
    .source_bits(source_bits),
    .done(done),
    .fp8_code(fp8_code),
    .cfg_write(cfg_write),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  initial clk = 1'b0;
  always #10 clk = ~clk;

  // Bit-exact conversion of one source word under the given formats
  function automatic logic [7:0] fp8_encode(logic [31:0] x, logic src_fmt, logic tgt_fmt);
    logic       sign;
    logic       e5m2;
    logic       keep_sub;
    logic [7:0] s8;
    logic [7:0] body;
    int         ef, mf, mw, eall, sbias;
    int         tmb, mmask, tbias, low, drop, te, tm, sh;
    e5m2 = (tgt_fmt == f2f8_pkg::TGT_E5M2);
    if (src_fmt == f2f8_pkg::SRC_FP32) begin
      sign = x[31]; ef = int'(x[30:23]); mf = int'(x[22:0]);
      mw = 23; sbias = 127; eall = 255; keep_sub = 1'b0;
    end else begin
      sign = x[15]; ef = int'(x[14:10]); mf = int'(x[9:0]);
      mw = 10; sbias = 15; eall = 31; keep_sub = e5m2;
    end
    tmb = e5m2 ? 2 : 3;
    mmask = (1 << tmb) - 1;
    tbias = e5m2 ? 15 : 7;
    low = e5m2 ? -2 : -3;
    drop = mw - tmb;
    s8 = {sign, 7'd0};

    if (ef == eall) begin
      if (!e5m2) return s8 | {1'b0, f2f8_pkg::E4M3_SAT};
      return s8 | {1'b0, (mf != 0) ? f2f8_pkg::E5M2_NAN : f2f8_pkg::E5M2_INF};
    end
    if (ef == 0 && mf == 0) return s8;

    te = ef - sbias + tbias;
    if (!e5m2 && te > 15) return s8 | {1'b0, f2f8_pkg::E4M3_SAT};
    if (e5m2 && te >= 31) return s8 | {1'b0, f2f8_pkg::E5M2_INF};

    if (ef == 0 && keep_sub) begin
      te = 0;
    end else if (te <= 0) begin
      // subnormal result: truncate, no rounding
      if (te < low) return s8;
      sh = 1 - te + drop;
      body = 8'(((mf | (1 << mw)) >> sh) & mmask);
      return s8 | body;
    end

    tm = (mf >> drop) + ((mf >> (drop - 1)) & 1);
    if (tm > mmask) begin
      tm = 0;
      te = te + 1;
    end
    if (!e5m2) begin
      if (te > 15 || (te == 15 && tm > 6)) return s8 | {1'b0, f2f8_pkg::E4M3_SAT};
    end else if (te >= 31) begin
      return s8 | {1'b0, f2f8_pkg::E5M2_INF};
    end
    body = 8'((te << tmb) | tm);
    return s8 | body;
  endfunction

  // Random words, partly shaped: exponents near the target range and rounding ties
  function automatic logic [31:0] random_source(logic src_fmt, logic tgt_fmt);
    logic [31:0] x;
    int          kind;
    int          drop;
    x = $urandom;
    kind = int'($urandom_range(0, 7));
    drop = ((src_fmt == f2f8_pkg::SRC_FP32) ? 23 : 10) -
           ((tgt_fmt == f2f8_pkg::TGT_E5M2) ? 2 : 3);
    if (src_fmt == f2f8_pkg::SRC_FP32 && kind >= 2) begin
      if (kind == 2) x[30:23] = {8{x[0]}};
      else x[30:23] = 8'($urandom_range(100, 150));
    end
    if (kind == 4) begin
      x = x & ~((32'd1 << drop) - 32'd1);
      x[drop-1] = 1'b1;
    end else if (kind == 5) begin
      x = x | ((32'd1 << (drop - 1)) - 32'd1);
      x[drop-1] = 1'b0;
    end else if (kind == 6 && src_fmt == f2f8_pkg::SRC_FP16) begin
      x[14:10] = 5'd0;
    end
    return x;
  endfunction

  task automatic report_mismatch(string what, logic [31:0] src, logic [7:0] want,
                                 logic [7:0] got);
    $display("MISMATCH %s: src=%08h expected=%02h got=%02h", what, src, want, got);
    mismatch_count++;
  endtask

  task automatic send_item(logic [31:0] x);
    @(negedge clk);
    start <= 1'b1;
    source_bits <= x;
    @(posedge clk);
    while (busy) @(posedge clk);
    expected_codes.push_back('{x, cur_src_fmt, cur_tgt_fmt,
                               fp8_encode(x, cur_src_fmt, cur_tgt_fmt)});
  endtask

  task automatic idle_for(int cycles);
    @(negedge clk);
    start <= 1'b0;
    repeat (cycles - 1) @(negedge clk);
  endtask

  task automatic drain;
    idle_for(1);
    while (expected_codes.size() != 0) @(posedge clk);
    repeat (PIPE_LATENCY + 1) @(posedge clk);
  endtask

  task automatic write_reg(logic idx, logic val);
    @(negedge clk);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    if (idx == f2f8_pkg::CFG_SOURCE_FORMAT) cur_src_fmt = val;
    else cur_tgt_fmt = val;
  endtask

  task automatic configure(logic src_fmt, logic tgt_fmt);
    drain();
    write_reg(f2f8_pkg::CFG_SOURCE_FORMAT, src_fmt);
    write_reg(f2f8_pkg::CFG_TARGET_FORMAT, tgt_fmt);
    @(negedge clk);
    cfg_write <= 1'b0;
  endtask

  // Reset formats: FP16 source, E4M3 target
  task automatic test_reset_defaults;
    send_item(32'h0000_0000);
    send_item(32'hFFFF_8000);  // upper bits ignored, negative zero
    send_item(32'h0000_7C00);  // infinity saturates
    send_item(32'h0000_7E00);  // NaN saturates
    send_item(32'h0000_5F00);  // 448
    send_item(32'hA5A5_0001);  // subnormal flushes
  endtask

  task automatic test_fp16_e5m2;
    configure(f2f8_pkg::SRC_FP16, f2f8_pkg::TGT_E5M2);
    send_item(32'h0000_0001);  // kept subnormal
    send_item(32'h0000_83FF);  // subnormal rounds up to smallest normal
    send_item(32'h0000_FBFF);  // rounding carry into infinity
    send_item(32'h0000_7E00);
    send_item(32'h0000_FC00);
    send_item(32'hFFFF_FFFF);
  endtask

  task automatic test_fp32_e4m3;
    configure(f2f8_pkg::SRC_FP32, f2f8_pkg::TGT_E4M3);
    send_item(32'h0000_0001);  // source subnormal
    send_item(32'h43E0_0000);  // 448
    send_item(32'h43F0_0000);  // above 448, saturates
    send_item(32'h7F80_0000);
    send_item(32'h3A80_0000);  // below smallest step
    send_item(32'hBB00_0000);  // smallest subnormal
  endtask

  task automatic test_fp32_e5m2;
    configure(f2f8_pkg::SRC_FP32, f2f8_pkg::TGT_E5M2);
    send_item(32'h7FC0_0000);
    send_item(32'hFF80_0000);
    send_item(32'h477F_FFFF);  // overflow by rounding
    send_item(32'h3780_0000);
    send_item(32'h8040_0000);
    send_item(32'h3F7F_FFFF);  // mantissa carry
  endtask

  task automatic test_random_phase(logic src_fmt, logic tgt_fmt, int count);
    int sent;
    int burst;
    configure(src_fmt, tgt_fmt);
    sent = 0;
    while (sent < count) begin
      burst = int'($urandom_range(1, 24));
      for (int i = 0; i < burst && sent < count; i++) begin
        send_item(random_source(cur_src_fmt, cur_tgt_fmt));
        sent++;
      end
      if ($urandom_range(0, 2) != 0) idle_for(int'($urandom_range(1, 6)));
    end
  endtask

  task automatic test_random;
    test_random_phase(f2f8_pkg::SRC_FP16, f2f8_pkg::TGT_E4M3, 75);
    test_random_phase(f2f8_pkg::SRC_FP32, f2f8_pkg::TGT_E5M2, 75);
    test_random_phase(f2f8_pkg::SRC_FP16, f2f8_pkg::TGT_E5M2, 75);
    test_random_phase(f2f8_pkg::SRC_FP32, f2f8_pkg::TGT_E4M3, 75);
    test_random_phase(1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)), 75);
    test_random_phase(1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)), 75);
  endtask

  // Result checker
  always @(posedge clk) begin
    fp8_expect_t exp_item;
    if (!rst && done) begin
      if (expected_codes.size() == 0) begin
        report_mismatch("unexpected result", 32'h0, 8'h0, fp8_code);
      end else begin
        exp_item = expected_codes.pop_front();
        if (fp8_code !== exp_item.code)
          report_mismatch($sformatf("fp8_code src_fmt=%0d tgt_fmt=%0d",
                                    exp_item.src_fmt, exp_item.tgt_fmt),
                          exp_item.src, exp_item.code, fp8_code);
      end
    end
  end

  // Watchdog: cycles with no transaction on either side
  always @(posedge clk) begin
    if (rst || (start && !busy) || done) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("== FAIL ==");
        $finish;
      end
    end
  end

  initial begin
    rst = 1'b1;
    start = 1'b0;
    source_bits = 32'h0;
    cfg_write = 1'b0;
    cfg_index = 1'b0;
    cfg_data = 1'b0;
    cur_src_fmt = f2f8_pkg::SRC_FP16;
    cur_tgt_fmt = f2f8_pkg::TGT_E4M3;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    test_reset_defaults();
    test_fp16_e5m2();
    test_fp32_e4m3();
    test_fp32_e5m2();
    test_random();

    idle_for(1);
    while (expected_codes.size() != 0) @(posedge clk);
    repeat (PIPE_LATENCY + 5) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
